FILE: hw/rtl/wnst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnst_pkg: shared types and constants
// op codes, status codes and defaults for the weighted neighbour table
// ----------------------------------------------------------------------------
package wnst_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int KEY_BITS_DEF    = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 16;
  localparam int WEIGHT_W = 16;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_UPSERT  = 3'd0,
    OP_ERASE   = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_LOOKUP  = 3'd3,
    OP_TOPN    = 3'd4,
    OP_ATLEAST = 3'd5
  } op_t;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  count;
  } req_t;

  typedef struct packed {
    logic                entry_valid;
    logic [KEY_W-1:0]    out_key;
    logic [WEIGHT_W-1:0] out_weight;
    logic [STATUS_W-1:0] status;
    logic                last;
  } rsp_t;

endpackage

FILE: hw/rtl/wnst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnst_if: valid/ready channel
// carries one word of the given payload type
// ----------------------------------------------------------------------------
interface wnst_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/weighted_neighbor_sorted_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_neighbor_sorted_table: sorted neighbour/weight table
// keys with weights, kept in descending (weight, key) order in a memory
// ----------------------------------------------------------------------------
// order of work: lookup scans the entries, then answers from S_RESP; erase
//   scans, then runs a removal pass; upsert scans, runs a removal pass if
//   the key is present, then shifts the tail down and drops the new entry in
// clear and unused codes answer at the acceptance edge; top N lists at once,
//   at-least scans first and then lists; listings stall while rsp.ready is low
// throughput: one word in flight at a time, listings then one word per cycle
// reset: entry count goes to zero; memory contents are left as they are
module weighted_neighbor_sorted_table
  import wnst_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  wnst_if.sink   req,
  wnst_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 2);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,  // read entry i, compare next cycle
    S_DEL   = 7'b0000100,  // shift tail up by one to remove
    S_INS   = 7'b0001000,  // shift tail down by one, then drop new entry in
    S_LIST  = 7'b0010000,  // stream entries out
    S_RESP  = 7'b0100000,  // single status word waits in output register
    S_DRAIN = 7'b1000000   // clear rd_vld after the final list word, then go idle
  } state_t;

  state_t state;

  // table memory, one word per entry
  logic [KEY_BITS+WEIGHT_BITS-1:0] mem [CAPACITY];
  logic [KEY_BITS+WEIGHT_BITS-1:0] rd_data;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [KEY_BITS+WEIGHT_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  wire [KEY_BITS-1:0]    rd_key = rd_data[KEY_BITS+WEIGHT_BITS-1:WEIGHT_BITS];
  wire [WEIGHT_BITS-1:0] rd_wt  = rd_data[WEIGHT_BITS-1:0];

  // latched request
  logic [OP_W-1:0]        op;
  logic [KEY_BITS-1:0]    key;
  logic [WEIGHT_BITS-1:0] wt;
  logic [CW-1:0]          n;      // list length
  logic [CW-1:0]          count;  // entries held
  logic [CW-1:0]          idx;    // entry being read
  logic                   rd_vld; // rd_data holds entry idx-1
  logic                   found;
  logic [CW-1:0]          fpos;   // position of matching key
  logic [CW-1:0]          ipos;   // insert position
  logic                   ipos_ok;
  logic                   ins_pend;
  logic [CW-1:0]          wptr;
  logic [WEIGHT_BITS-1:0] lookup_wt;

  // output register
  rsp_t out_q;
  logic out_v;
  assign rsp.valid = out_v;
  assign rsp.data  = out_q;
  wire out_free = !out_v || rsp.ready;

  assign req.ready = (state == S_IDLE) && out_free;

  wire [CW-1:0] idx_m1 = idx - CW'(1);
  wire sorts_after = (rd_wt > wt) || ((rd_wt == wt) && (rd_key > key));

  function automatic rsp_t mk(input logic v, input logic [KEY_W-1:0] k,
                              input logic [WEIGHT_W-1:0] w,
                              input logic [STATUS_W-1:0] s, input logic l);
    rsp_t r;
    r.entry_valid = v;
    r.out_key     = k;
    r.out_weight  = w;
    r.status      = s;
    r.last        = l;
    return r;
  endfunction

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    if (state == S_SCAN || state == S_DEL || state == S_INS ||
        (state == S_LIST && out_free))
      rd_en = 1'b1;
    if (state == S_INS) rd_addr = wptr[AW-1:0] - AW'(1);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr[AW-1:0];
    wr_data = rd_data;
    if (state == S_DEL && rd_vld) begin
      wr_en   = (idx < count + CW'(1));
      wr_addr = idx[AW-1:0] - AW'(2);
    end else if (state == S_INS) begin
      wr_en = 1'b1;
      if (!rd_vld || wptr == ipos) begin
        wr_en   = (wptr == ipos);
        wr_data = {key, wt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      out_v    <= 1'b0;
      rd_vld   <= 1'b0;
      ins_pend <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op       <= req.data.op;
            key      <= req.data.key[KEY_BITS-1:0];
            wt       <= req.data.weight[WEIGHT_BITS-1:0];
            idx      <= '0;
            rd_vld   <= 1'b0;
            found    <= 1'b0;
            ipos_ok  <= 1'b0;
            ipos     <= count;
            ins_pend <= 1'b0;
            if (req.data.op == OP_TOPN) begin
              n     <= (req.data.count < COUNT_W'(count)) ? CW'(req.data.count) : count;
              state <= S_LIST;
            end else if (req.data.op == OP_CLEAR) begin
              count <= '0;
              out_q <= mk(1'b0, '0, '0, ST_DONE, 1'b1);
              out_v <= 1'b1;
            end else if (req.data.op == OP_UPSERT || req.data.op == OP_ERASE ||
                         req.data.op == OP_LOOKUP || req.data.op == OP_ATLEAST) begin
              n     <= count;
              state <= S_SCAN;
            end else begin
              out_q <= mk(1'b0, '0, '0, ST_DONE, 1'b1);
              out_v <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // rd_data holds entry idx-1 when rd_vld
          rd_vld <= (idx < count);
          idx    <= idx + CW'(1);
          if (rd_vld) begin
            if (rd_key == key && !found) begin
              found <= 1'b1;
              fpos  <= idx_m1;
            end
            // insert position, skipping the entry of the same key
            if (op == OP_UPSERT && !ipos_ok && !sorts_after && !(rd_key == key)) begin
              ipos_ok <= 1'b1;
              ipos    <= idx_m1;
            end
            // first entry below the threshold ends the listing
            if (op == OP_ATLEAST && rd_wt < wt && !ipos_ok) begin
              ipos_ok <= 1'b1;
              n       <= idx_m1;
            end
          end
          if (idx >= count + CW'(1) || (!rd_vld && idx >= count && idx != '0) ||
              (count == '0)) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          rd_vld <= 1'b0;
          if (op == OP_ATLEAST) begin
            idx   <= '0;
            state <= S_LIST;
          end else if (out_free) begin
            out_v <= 1'b1;
            state <= S_IDLE;
            unique case (op)
              OP_LOOKUP:
                out_q <= mk(1'b1, KEY_W'(key), found ? WEIGHT_W'(lookup_wt) : '0,
                            found ? ST_DONE : ST_ABSENT, 1'b1);
              OP_ERASE: begin
                out_q <= mk(1'b0, '0, '0, found ? ST_DONE : ST_ABSENT, 1'b1);
                if (found) begin
                  out_v <= 1'b0;
                  idx   <= fpos + CW'(1);
                  state <= S_DEL;
                end
              end
              default: begin // upsert
                if (!found && count >= CAP) begin
                  out_q <= mk(1'b0, '0, '0, ST_FULL, 1'b1);
                end else begin
                  out_q <= mk(1'b0, '0, '0, ST_DONE, 1'b1);
                  out_v <= 1'b0;
                  ins_pend <= 1'b1;
                  if (found) begin
                    idx   <= fpos + CW'(1);
                    state <= S_DEL;
                  end else begin
                    wptr  <= count;
                    state <= S_INS;
                  end
                end
              end
            endcase
          end
        end
        S_DEL: begin
          // move entries fpos+1..count-1 up by one
          rd_vld <= 1'b1;
          idx    <= idx + CW'(1);
          if (rd_vld && idx >= count + CW'(1)) begin
            rd_vld <= 1'b0;
            count  <= count - CW'(1);
            if (ins_pend) begin
              // entries before fpos keep order; past fpos shift by one
              if (ipos > fpos) ipos <= ipos - CW'(1);
              wptr  <= count - CW'(1);
              state <= S_INS;
            end else begin
              out_v <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_INS: begin
          // move entries down from the tail, reading wptr-1 writing wptr
          if (wptr == ipos) begin
            if (wr_en) begin
              count    <= count + CW'(1);
              ins_pend <= 1'b0;
              rd_vld   <= 1'b0;
              out_v    <= 1'b1;
              state    <= S_IDLE;
            end
          end else begin
            rd_vld <= 1'b1;
            if (rd_vld) begin
              wptr   <= wptr - CW'(1);
              rd_vld <= 1'b0;
            end
          end
        end
        S_LIST: begin
          if (n == '0) begin
            if (out_free) begin
              out_q <= mk(1'b0, '0, '0, ST_DONE, 1'b1);
              out_v <= 1'b1;
              state <= S_IDLE;
            end
          end else if (out_free) begin
            rd_vld <= rd_en && (idx < n);
            if (idx < n) idx <= idx + CW'(1);
            if (rd_vld) begin
              out_q <= mk(1'b1, KEY_W'(rd_key), WEIGHT_W'(rd_wt), ST_DONE,
                          idx_m1 == n - CW'(1));
              out_v <= 1'b1;
              if (idx_m1 == n - CW'(1)) state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          rd_vld <= 1'b0;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // weight of matched entry captured during the scan
  always_ff @(posedge clk) begin
    if (state == S_SCAN && rd_vld && rd_key == key && !found) lookup_wt <= rd_wt;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("entry count beyond capacity");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE)
    else $error("request taken while busy");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.data.op == OP_CLEAR) |=> count == '0)
    else $error("clear left entries");
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && wptr == ipos && wr_en) |=> count == $past(count) + CW'(1))
    else $error("insert did not grow table");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the weighted neighbour table
// drives request words through a valid/ready channel, predicts every response
// word from a local sorted table and checks the responses in order
// ----------------------------------------------------------------------------
module tb_top;
  import wnst_pkg::*;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  wnst_if #(.payload_t(req_t)) req ();
  wnst_if #(.payload_t(rsp_t)) rsp ();

  weighted_neighbor_sorted_table dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // predicted table, sorted by descending weight then descending key
  logic [15:0] tbl_key [CAP];
  logic [15:0] tbl_wt [CAP];
  int          tbl_n;

  rsp_t   pending_words[$];
  int     errors = 0;
  int     words_seen = 0;
  int     cycles = 0;
  int     hold_len = 0;  // length of a long receiver stall
  int     hold_tag = 0;  // bumped to start a stall in the sink process
  int     fills;
  bit     quiet_sink; // stretch without receiver idling

  function automatic rsp_t word(logic v, logic [15:0] k, logic [15:0] w,
                                logic [1:0] s, logic l);
    rsp_t r;
    r.entry_valid = v;
    r.out_key     = k;
    r.out_weight  = w;
    r.status      = s;
    r.last        = l;
    return r;
  endfunction

  function automatic void queue_word(rsp_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic int find_slot(logic [15:0] k);
    for (int i = 0; i < tbl_n; i++)
      if (tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int p);
    for (int i = p; i < tbl_n - 1; i++) begin
      tbl_key[i] = tbl_key[i+1];
      tbl_wt[i]  = tbl_wt[i+1];
    end
    tbl_n--;
  endfunction

  function automatic void place_sorted(logic [15:0] k, logic [15:0] w);
    int p;
    p = 0;
    while (p < tbl_n && (tbl_wt[p] > w || (tbl_wt[p] == w && tbl_key[p] > k)))
      p++;
    for (int i = tbl_n; i > p; i--) begin
      tbl_key[i] = tbl_key[i-1];
      tbl_wt[i]  = tbl_wt[i-1];
    end
    tbl_key[p] = k;
    tbl_wt[p]  = w;
    tbl_n++;
  endfunction

  // applies one request to the local table and queues the words it yields
  function automatic void predict_table_op(req_t r);
    int p;
    int n;
    p = find_slot(r.key);
    case (r.op)
      OP_UPSERT: begin
        if (p < 0 && tbl_n >= CAP) begin
          queue_word(word(1'b0, '0, '0, ST_FULL, 1'b1));
        end else begin
          if (p >= 0) drop_slot(p);
          place_sorted(r.key, r.weight);
          queue_word(word(1'b0, '0, '0, ST_DONE, 1'b1));
        end
      end
      OP_ERASE: begin
        if (p < 0) begin
          queue_word(word(1'b0, '0, '0, ST_ABSENT, 1'b1));
        end else begin
          drop_slot(p);
          queue_word(word(1'b0, '0, '0, ST_DONE, 1'b1));
        end
      end
      OP_CLEAR: begin
        tbl_n = 0;
        queue_word(word(1'b0, '0, '0, ST_DONE, 1'b1));
      end
      OP_LOOKUP: begin
        if (p < 0) queue_word(word(1'b1, r.key, '0, ST_ABSENT, 1'b1));
        else queue_word(word(1'b1, r.key, tbl_wt[p], ST_DONE, 1'b1));
      end
      OP_TOPN, OP_ATLEAST: begin
        if (r.op == OP_TOPN) begin
          n = (r.count < tbl_n) ? r.count : tbl_n;
        end else begin
          n = 0;
          while (n < tbl_n && tbl_wt[n] >= r.weight) n++;
        end
        if (n == 0) queue_word(word(1'b0, '0, '0, ST_DONE, 1'b1));
        for (int i = 0; i < n; i++)
          queue_word(word(1'b1, tbl_key[i], tbl_wt[i], ST_DONE, (i == n - 1)));
      end
      default: queue_word(word(1'b0, '0, '0, ST_DONE, 1'b1));
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: ready changes at the falling edge
  initial begin
    int gap;
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        rsp.ready = 1'b0;
        hold_left--;
      end else if (quiet_sink) begin
        rsp.ready = 1'b1;
      end else begin
        gap = gap_len();
        if (gap > 0) begin
          rsp.ready = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else begin
          rsp.ready = 1'b1;
        end
      end
    end
  end

  // response checker, sampled at the rising edge
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = rsp.data;
      words_seen++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %p", $time, got);
      end else begin
        want = pending_words.pop_front();
        if (got.entry_valid !== want.entry_valid || got.out_key !== want.out_key ||
            got.out_weight !== want.out_weight || got.status !== want.status ||
            got.last !== want.last) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  // offers one request at the falling edge and waits for its acceptance
  task automatic send_req(op_t op, logic [15:0] k, logic [15:0] w, logic [6:0] c);
    req_t r;
    r.op = op;
    r.key = k;
    r.weight = w;
    r.count = c;
    req.data = r;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    predict_table_op(r);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic send_gapped(op_t op, logic [15:0] k, logic [15:0] w, logic [6:0] c);
    send_req(op, k, w, c);
    repeat (gap_len()) @(negedge clk);
  endtask

  task automatic drain_responses();
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  // random key, drawn from the table half the time when it is not empty
  function automatic logic [15:0] pick_key();
    if (tbl_n > 0 && $urandom_range(0, 1)) return tbl_key[$urandom_range(0, tbl_n - 1)];
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  task automatic test_directed_ops();
    send_gapped(OP_TOPN, '0, '0, 7'd5);          // listing on an empty table
    send_gapped(OP_ATLEAST, '0, '0, '0);
    send_gapped(OP_LOOKUP, 16'hFFFF, '0, '0);     // lookup of an absent key
    send_gapped(OP_ERASE, 16'h1234, '0, '0);      // erase of an absent key
    send_gapped(OP_UPSERT, 16'hFFFF, 16'hFFFF, '0);
    send_gapped(OP_UPSERT, 16'h0000, 16'h0000, '0);
    send_gapped(OP_UPSERT, 16'h00AA, 16'h0100, '0);
    send_gapped(OP_UPSERT, 16'h00BB, 16'h0100, '0); // equal weights, key order
    send_gapped(OP_UPSERT, 16'h00AA, 16'h0001, '0); // overwrite moves the key
    send_gapped(OP_LOOKUP, 16'h00AA, '0, '0);
    send_gapped(OP_TOPN, '0, 16'hFFFF, 7'd0);    // zero count
    send_gapped(OP_TOPN, '0, '0, 7'd2);
    send_gapped(OP_TOPN, '0, '0, 7'd127);         // count saturates
    send_gapped(OP_ATLEAST, '0, 16'h0000, '0);    // every entry qualifies
    send_gapped(OP_ATLEAST, 16'hFFFF, 16'h0100, '0); // ties with a large key
    send_gapped(OP_ATLEAST, '0, 16'hFFFF, '0);
    send_gapped(op_t'(3'd6), 16'h5555, 16'hAAAA, 7'h55); // unused codes
    send_gapped(op_t'(3'd7), 16'hAAAA, 16'h5555, 7'h2A);
    send_gapped(OP_ERASE, 16'h00BB, '0, '0);
    send_gapped(OP_CLEAR, '0, '0, '0);
    send_gapped(OP_LOOKUP, 16'hFFFF, '0, '0);
  endtask

  // fill to capacity, try one more, then list everything with the sink stalled
  task automatic test_full_table();
    fills = 0;
    while (tbl_n < CAP) begin
      send_req(OP_UPSERT, 16'($urandom), 16'($urandom_range(0, 7)), '0);
      fills++;
    end
    send_req(OP_UPSERT, 16'hFFFF - 16'(tbl_n), 16'h7FFF, '0);
    if (find_slot(tbl_key[0]) >= 0) send_req(OP_UPSERT, tbl_key[CAP-1], 16'hFFF0, '0);
    drain_responses();
    hold_len = 300;
    hold_tag++;
    repeat (6) send_req(OP_TOPN, '0, '0, 7'd64);
    send_req(OP_ATLEAST, '0, 16'h0000, '0);
    drain_responses();
  endtask

  task automatic test_random_mix();
    op_t  op;
    int   roll;
    for (int i = 0; i < 16; i++) begin
      if (i == 6) begin
        // sender waits for every word, then a stretch with no idling
        drain_responses();
        quiet_sink = 1'b1;
      end
      if (i == 11) quiet_sink = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 40) op = OP_UPSERT;
      else if (roll < 55) op = OP_ERASE;
      else if (roll < 58) op = OP_CLEAR;
      else if (roll < 75) op = OP_LOOKUP;
      else if (roll < 87) op = OP_TOPN;
      else if (roll < 97) op = OP_ATLEAST;
      else op = op_t'(3'($urandom_range(6, 7)));
      if (i < 6 || i >= 11) send_gapped(op, pick_key(), 16'($urandom),
                                        7'($urandom_range(0, 70)));
      else send_req(op, pick_key(), 16'($urandom_range(0, 65535)),
                    7'($urandom));
    end
  endtask

  initial begin
    quiet_sink = 1'b0;
    tbl_n = 0;
    req.valid = 1'b0;
    req.data = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed_ops();
    test_full_table();
    test_random_mix();
    drain_responses();
    repeat (300) @(negedge clk);
    $display("covered directed cases, a full table of %0d inserts with stalled output,",
             fills);
    $display("and a random operation mix: %0d response words checked", words_seen);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
